// ----- rtl/gated_harmonic_tone_synth_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the gated harmonic tone synth
// Each macro expands to a labeled concurrent assertion, or to nothing when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GATED_HARMONIC_TONE_SYNTH_ASSERT_SVH
`define GATED_HARMONIC_TONE_SYNTH_ASSERT_SVH

`ifndef SYNTHESIS
// check while out of reset
`define GHTS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// check on every edge, reset included
`define GHTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GHTS_ASSERT(lbl, clk, rstn, prop, msg)
`define GHTS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/ghts_pkg.sv -----
// ----------------------------------------------------------------------------
// ghts_pkg
// Shared constants, sine quarter table, command and status types.
// ----------------------------------------------------------------------------
package ghts_pkg;

    localparam int FIRST_BEAT      = 2;
    localparam int LAST_BEAT       = 9;
    localparam int BEAT_PERIOD     = 96;
    localparam int SINE_TABLE_BITS = 10;

    localparam int NUM_BEATS  = LAST_BEAT - FIRST_BEAT + 1;
    localparam int HARMONICS  = 3;
    localparam int BEAT_W     = $clog2(NUM_BEATS);
    localparam int HARM_W     = $clog2(HARMONICS);
    localparam int BNUM_W     = $clog2(LAST_BEAT + 1);
    localparam int K_W        = $clog2(LAST_BEAT * HARMONICS + 1);
    localparam int COUNT_W    = $clog2(BEAT_PERIOD * LAST_BEAT);
    localparam int PHASE_W    = 32;
    localparam int GAIN_W     = 16;
    localparam int SAMPLE_W   = 16;
    localparam int SINE_W     = 16;
    localparam int WEIGHT_W   = 16;
    localparam int VACC_W     = 32;
    localparam int VTERM_W    = VACC_W - 15;
    localparam int SUM_W      = 20;
    localparam int SCALED_W   = SUM_W + GAIN_W + 1;
    localparam int GAIN_SHIFT = 19;
    localparam int QBITS      = SINE_TABLE_BITS - 2;
    localparam int QUARTER    = 1 << QBITS;
    localparam int DRAIN_CYCLES = 4;
    localparam int DRAIN_W    = $clog2(DRAIN_CYCLES + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN = 1'd1;

    localparam logic [PHASE_W-1:0] PHASE_STEP_RESET  = 32'd42852278;
    localparam logic [GAIN_W-1:0]  OUTPUT_GAIN_RESET = 16'd32767;

    localparam longint unsigned C1 = 64'd1686629713;
    localparam longint unsigned C3 = 64'd693598668;
    localparam longint unsigned C5 = 64'd85569306;
    localparam longint unsigned C7 = 64'd5026995;
    localparam longint unsigned C9 = 64'd172272;

    typedef logic [SINE_W-2:0] t_sine_qtr [QUARTER+1];
    typedef logic [WEIGHT_W-1:0] t_weights [HARMONICS];

    localparam t_weights HARM_WEIGHT = '{16'd32768, 16'd16384, 16'd10922};

    function automatic t_sine_qtr sine_qtr_build();
        t_sine_qtr tbl;
        longint unsigned x, x2, poly, s;
        for (int r = 0; r <= QUARTER; r++) begin
            x    = longint'(r) << (30 - QBITS);
            x2   = (x * x) >> 30;
            poly = C7 - ((x2 * C9) >> 30);
            poly = C5 - ((x2 * poly) >> 30);
            poly = C3 - ((x2 * poly) >> 30);
            poly = C1 - ((x2 * poly) >> 30);
            s    = (x * poly) >> 30;
            s    = (s + 64'd16384) >> 15;
            if (s > 64'd32767) begin
                s = 64'd32767;
            end
            tbl[r] = s[SINE_W-2:0];
        end
        return tbl;
    endfunction

    localparam t_sine_qtr SINE_QTR = sine_qtr_build();

    function automatic logic [COUNT_W-1:0] beat_period(input logic [BEAT_W-1:0] b);
        return COUNT_W'(BEAT_PERIOD * (FIRST_BEAT + int'(b)));
    endfunction

    typedef struct packed {
        logic              start;
        logic              restart;
        logic              issue;
        logic [BEAT_W-1:0] beat;
        logic [HARM_W-1:0] harm;
        logic              scale;
        logic              commit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

// ----- rtl/ghts_ctrl.sv -----
// ----------------------------------------------------------------------------
// ghts_ctrl
// Sequencer: accepts a tick, issues one sine term per cycle, drains the
// datapath, scales and hands the sample to the output register.
// ----------------------------------------------------------------------------
module ghts_ctrl
    import ghts_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_restart,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_RUN   = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_SCALE = 5'b01000,
        ST_WRITE = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [BEAT_W-1:0]   r_beat, n_beat;
    logic [HARM_W-1:0]   r_harm, n_harm;
    logic [DRAIN_W-1:0]  r_drain, n_drain;
    logic                w_last_term;

    assign w_last_term = (r_beat == BEAT_W'(NUM_BEATS - 1)) &&
                         (r_harm == HARM_W'(HARMONICS - 1));

    always_comb begin
        n_state = r_state;
        n_beat  = r_beat;
        n_harm  = r_harm;
        n_drain = r_drain;
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        o_cmd.beat    = r_beat;
        o_cmd.harm    = r_harm;
        o_cmd.restart = i_restart;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_beat  = '0;
                    n_harm  = '0;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd.issue = 1'b1;
                if (r_harm == HARM_W'(HARMONICS - 1)) begin
                    n_harm = '0;
                    n_beat = r_beat + BEAT_W'(1);
                end else begin
                    n_harm = r_harm + HARM_W'(1);
                end
                if (w_last_term) begin
                    n_drain = '0;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_drain = r_drain + DRAIN_W'(1);
                if (r_drain == DRAIN_W'(DRAIN_CYCLES - 1)) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_beat  <= '0;
            r_harm  <= '0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_beat  <= n_beat;
            r_harm  <= n_harm;
            r_drain <= n_drain;
        end
    end

endmodule

// ----- rtl/ghts_datapath.sv -----
// ----------------------------------------------------------------------------
// ghts_datapath
// Phase and beat counters, sine term pipeline, voice and sample
// accumulators, gain scaling, saturation and the output register.
// ----------------------------------------------------------------------------
module ghts_datapath
    import ghts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [SAMPLE_W-1:0]   o_out_sample
);

    logic [PHASE_W-1:0]   r_step;
    logic [GAIN_W-1:0]    r_gain;
    logic [PHASE_W-1:0]   r_phase;
    logic [COUNT_W-1:0]   r_count [NUM_BEATS];

    // term pipeline
    logic                        r_s1_vld, r_s1_gate, r_s1_first, r_s1_last;
    logic [HARM_W-1:0]           r_s1_harm;
    logic [SINE_TABLE_BITS-1:0]  r_s1_idx;
    logic                        r_s2_vld, r_s2_gate, r_s2_first, r_s2_last;
    logic [HARM_W-1:0]           r_s2_harm;
    logic signed [SINE_W-1:0]    r_s2_sine;
    logic                        r_s3_vld, r_s3_gate, r_s3_first, r_s3_last;
    logic signed [VACC_W-1:0]    r_s3_prod;
    logic signed [VACC_W-1:0]    r_vacc;
    logic                        r_s4_vld;
    logic signed [VACC_W-1:0]    r_s4_t;
    logic signed [SUM_W-1:0]     r_sum;
    logic signed [SCALED_W-1:0]  r_scaled;
    logic                        r_out_valid;
    logic [SAMPLE_W-1:0]         r_out_sample;

    logic [BNUM_W-1:0]              w_bnum;
    logic [K_W-1:0]                 w_hnum, w_k;
    logic [PHASE_W+K_W-1:0]         w_ph_prod;
    logic                           w_gate;
    logic [1:0]                     w_quad;
    logic [QBITS:0]                 w_addr;
    logic [SINE_W-2:0]              w_mag;
    logic signed [SINE_W-1:0]       w_sine;
    logic signed [SINE_W+WEIGHT_W:0] w_prod;
    logic signed [VACC_W-1:0]       w_t;
    logic signed [VACC_W-1:0]       w_biased;
    logic signed [VTERM_W-1:0]      w_vterm;
    logic signed [SCALED_W-1:0]     w_scl;
    logic signed [SCALED_W-1:0]     w_sbias;
    logic signed [SCALED_W-GAIN_SHIFT-1:0] w_q;
    logic [SAMPLE_W-1:0]            w_sat;
    logic [PHASE_W:0]               w_next_phase;

    assign w_bnum    = BNUM_W'(FIRST_BEAT) + BNUM_W'(i_cmd.beat);
    assign w_hnum    = K_W'(i_cmd.harm) + K_W'(1);
    assign w_k       = K_W'(K_W'(w_bnum) * w_hnum);
    assign w_ph_prod = {{K_W{1'b0}}, r_phase} * {{PHASE_W{1'b0}}, w_k};
    assign w_gate    = {r_count[i_cmd.beat], r_phase[PHASE_W-1 -: 3]}
                       < {3'b000, beat_period(i_cmd.beat)};

    assign w_quad = r_s1_idx[SINE_TABLE_BITS-1 -: 2];
    assign w_addr = w_quad[0] ? ((QBITS+1)'(QUARTER) - {1'b0, r_s1_idx[QBITS-1:0]})
                              : {1'b0, r_s1_idx[QBITS-1:0]};
    assign w_mag  = SINE_QTR[w_addr];
    assign w_sine = w_quad[1] ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});

    assign w_prod = (SINE_W+WEIGHT_W+1)'(r_s2_sine) *
                    (SINE_W+WEIGHT_W+1)'($signed({1'b0, HARM_WEIGHT[r_s2_harm]}));

    assign w_t = (r_s3_first ? '0 : r_vacc) + r_s3_prod;

    assign w_biased = r_s4_t + (r_s4_t[VACC_W-1] ? VACC_W'(32767) : VACC_W'(0));
    assign w_vterm  = w_biased[VACC_W-1:15];

    assign w_scl   = SCALED_W'(r_sum) * SCALED_W'($signed({1'b0, r_gain}));
    assign w_sbias = r_scaled + (r_scaled[SCALED_W-1] ? SCALED_W'((1 << GAIN_SHIFT) - 1)
                                                      : SCALED_W'(0));
    assign w_q     = w_sbias[SCALED_W-1:GAIN_SHIFT];

    always_comb begin
        if (w_q > $signed((SCALED_W-GAIN_SHIFT)'(32767))) begin
            w_sat = 16'h7fff;
        end else if (w_q < -$signed((SCALED_W-GAIN_SHIFT)'(32768))) begin
            w_sat = 16'h8000;
        end else begin
            w_sat = w_q[SAMPLE_W-1:0];
        end
    end

    assign w_next_phase = {1'b0, r_phase} + {1'b0, r_step};

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= PHASE_STEP_RESET;
            r_gain <= OUTPUT_GAIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PHASE_STEP:  r_step <= i_cfg_data[PHASE_W-1:0];
                REG_OUTPUT_GAIN: r_gain <= i_cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // phase and beat counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            for (int b = 0; b < NUM_BEATS; b++) begin
                r_count[b] <= '0;
            end
        end else if (i_cmd.start && i_cmd.restart) begin
            r_phase <= '0;
            for (int b = 0; b < NUM_BEATS; b++) begin
                r_count[b] <= '0;
            end
        end else if (i_cmd.commit) begin
            r_phase <= w_next_phase[PHASE_W-1:0];
            if (w_next_phase[PHASE_W]) begin
                for (int b = 0; b < NUM_BEATS; b++) begin
                    if (r_count[b] == beat_period(BEAT_W'(b)) - COUNT_W'(1)) begin
                        r_count[b] <= '0;
                    end else begin
                        r_count[b] <= r_count[b] + COUNT_W'(1);
                    end
                end
            end
        end
    end

    // term pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.issue;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld && r_s3_last && r_s3_gate;
        end
    end

    // term pipeline payload
    always_ff @(posedge i_clk) begin
        r_s1_idx   <= w_ph_prod[PHASE_W-1 -: SINE_TABLE_BITS];
        r_s1_harm  <= i_cmd.harm;
        r_s1_gate  <= w_gate;
        r_s1_first <= (i_cmd.harm == '0);
        r_s1_last  <= (i_cmd.harm == HARM_W'(HARMONICS - 1));

        r_s2_sine  <= w_sine;
        r_s2_harm  <= r_s1_harm;
        r_s2_gate  <= r_s1_gate;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;

        r_s3_prod  <= w_prod[VACC_W-1:0];
        r_s3_gate  <= r_s2_gate;
        r_s3_first <= r_s2_first;
        r_s3_last  <= r_s2_last;

        if (r_s3_vld) begin
            r_vacc <= w_t;
            r_s4_t <= w_t;
        end

        if (i_cmd.scale) begin
            r_scaled <= w_scl;
        end
    end

    // sample accumulator
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_sum <= '0;
        end else if (r_s4_vld) begin
            r_sum <= r_sum + {{(SUM_W-VTERM_W){w_vterm[VTERM_W-1]}}, w_vterm};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_sample <= w_sat;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_sample    = r_out_sample;

endmodule

// ----- rtl/gated_harmonic_tone_synth.sv -----
// ----------------------------------------------------------------------------
// gated_harmonic_tone_synth
// Gated additive tone generator: one signed 16-bit sample per tick.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one beat per sample tick; tdata bit 0 is restart, which
//   clears the phase and all beat counters before the sample is formed.
//   Master stream: one beat per tick carrying the signed 16-bit sample.
//   Config port: i_cfg_we writes i_cfg_data to register i_cfg_idx
//   (0 phase_step, 1 output_gain); write only while idle.
//   Sequence: from the accepted input beat to o_m_tvalid, an accept
//   state, 24 term issues (8 beats x 3 harmonics through the one sine
//   table and weight multiplier), the pipeline drain, the gain step
//   and the output register.
//   The shared term pipeline takes one tick at a time, up to its commit.
//   Reset: phase, beat counters and registers return to reset values, no
//   result pending, o_s_tready high.
//   Stall: a finished sample holds in the output register; the next tick is
//   accepted and computed, then holds before commit until that register
//   frees.
// ----------------------------------------------------------------------------
`include "gated_harmonic_tone_synth_assert.svh"

module gated_harmonic_tone_synth
    import ghts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,   // [0] restart, [7:1] zero
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [SAMPLE_W-1:0]   o_m_tdata,   // [15:0] sample
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    ghts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_restart  (i_s_tdata[0]),
        .o_in_ready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ghts_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_out_ready  (i_m_tready),
        .o_out_valid  (o_m_tvalid),
        .o_out_sample (o_m_tdata)
    );

    `GHTS_ASSERT(a_one_tick_at_a_time, i_clk, i_rst_n, (i_s_tvalid && o_s_tready) |=> !o_s_tready, "second tick accepted while busy")
    `GHTS_ASSERT_ALWAYS(a_no_issue_when_ready, i_clk, !(o_s_tready && w_cmd.issue), "term issued while idle")
    `GHTS_ASSERT(a_out_from_commit, i_clk, i_rst_n, $rose(o_m_tvalid) |-> $past(w_cmd.commit), "output valid without commit")
    `GHTS_ASSERT(a_commit_only_free, i_clk, i_rst_n, w_cmd.commit |-> (!o_m_tvalid || i_m_tready), "commit over a pending sample")

endmodule
